// ----- src/hmtc_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// hmtc_pkg: shared types and constants for the heightmap terrain collision core
// Item layouts, register indexes, controller states and Q16.16 helpers.
// ---------------------------------------------------------------------------
package hmtc_pkg;

  localparam int MAP_SIDE_DEF     = 128;
  localparam int HEIGHT_WIDTH_DEF = 32;

  localparam int CFG_W     = 32;  // widest register
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 16;  // interpolation fraction bits
  localparam int CELL_W    = 8;   // integer quotient bits (cell index <= 127)
  localparam int QUOT_W    = CELL_W + FRAC_W;
  localparam int NUM_W     = 39;  // doubled grid coordinate, 0 .. 2*127*(2^31-1)
  localparam int DEN_W     = 32;  // doubled spacing
  localparam int GEO_W     = 42;  // signed width for extent and center math

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SPACING = 3'd0,
    REG_ORIGIN_X     = 3'd1,
    REG_ORIGIN_Y     = 3'd2,
    REG_ORIGIN_Z     = 3'd3,
    REG_LAST_COLUMN  = 3'd4,
    REG_LAST_ROW     = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_BOX  = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EXTENT,
    ST_CHECK,
    ST_DIVIDE,
    ST_READ,
    ST_INTERP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic               kind;
    logic [6:0]         sample_row;
    logic [6:0]         sample_column;
    logic signed [31:0] sample_height;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
  } req_item_t;

  typedef struct packed {
    logic               collides;
    logic               on_grid;
    logic signed [31:0] surface_height;
    logic signed [31:0] terrain_low;
    logic signed [31:0] terrain_high;
  } rsp_item_t;

  // Saturate a 34-bit signed sum to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/hmtc_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// hmtc_if: valid/ready channels of the terrain collision core
// Request channel carries loads and box tests, response channel the results.
// ---------------------------------------------------------------------------
interface hmtc_req_if;
  import hmtc_pkg::*;
  logic      valid;
  logic      ready;
  req_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface hmtc_rsp_if;
  import hmtc_pkg::*;
  logic      valid;
  logic      ready;
  rsp_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

// ----- src/hmtc_div.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// hmtc_div: radix-2 restoring divider for grid coordinates
// Produces an 8-bit cell index and a 16-bit fraction, one bit per cycle.
// ---------------------------------------------------------------------------
module hmtc_div
  import hmtc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DEN_W-1:0]  den,
  output logic                   done,
  output logic [QUOT_W-1:0]      quot
);

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [DEN_W:0]       rem;
  logic [DEN_W-1:0]     den_r;
  logic [QUOT_W-1:0]    bits;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic [DEN_W+1:0]     trial;
  logic                 fits;

  // Quotient is known to be below 2^24, so the top numerator bits start
  // as a partial remainder already smaller than the divisor.
  assign trial = {rem, bits[QUOT_W-1]};
  assign fits  = trial >= {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNT_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= (DEN_W+1)'(num[NUM_W-1:CELL_W]);
      bits  <= {num[CELL_W-1:0], {FRAC_W{1'b0}}};
      den_r <= den;
      cnt   <= CNT_W'(QUOT_W);
    end else if (busy) begin
      if (fits) begin
        rem <= (DEN_W+1)'(trial - {2'b00, den_r});
      end else begin
        rem <= trial[DEN_W:0];
      end
      quot <= {quot[QUOT_W-2:0], fits};
      bits <= {bits[QUOT_W-2:0], 1'b0};
      cnt  <= cnt - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

// ----- src/heightmap_terrain_collision_core.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// heightmap_terrain_collision_core: heightmap store and box-vs-terrain test
// Holds the height samples and running bounds, answers one item at a time.
// ---------------------------------------------------------------------------
// Usage:
//   req  : valid/ready request channel. kind 0 loads one height sample,
//          kind 1 tests a box against the terrain surface.
//   rsp  : valid/ready response channel, exactly one result per request.
//   cfg  : write port (cfg_we, cfg_index, cfg_data); write only while idle.
// Flow:
//   A load passes through the load and finish states, then raises rsp.valid.
//   A box test runs the extent and overlap checks, then two
//   24-step restoring dividers running side by side, four reads through
//   the one read port of the height memory, three shared multiply-add passes
//   for the bilinear blend and the result stage. Box tests that
//   miss the terrain skip the divide, the reads and the blend.
//   One item is in flight at a time; req.ready is high only when idle.
// Reset: clears config registers to their defaults, running min/max to zero and
//   drops rsp.valid. Height memory is not cleared.
// Stall: a result waiting on rsp holds in the output register; the core
//   returns to idle and takes the next request, which then waits in its
//   final stage until the output register is free.
// ---------------------------------------------------------------------------
module heightmap_terrain_collision_core
  import hmtc_pkg::*;
#(
  parameter int MAP_SIDE     = MAP_SIDE_DEF,
  parameter int HEIGHT_WIDTH = HEIGHT_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  hmtc_req_if.sink                  req,
  hmtc_rsp_if.source                rsp
);

  localparam int SW     = (HEIGHT_WIDTH < 32) ? HEIGHT_WIDTH : 32;
  localparam int IDX_W  = (MAP_SIDE > 2) ? $clog2(MAP_SIDE) : 1;
  localparam int ADDR_W = $clog2(MAP_SIDE * MAP_SIDE);
  localparam int DEPTH  = MAP_SIDE * MAP_SIDE;

  // Configuration registers
  logic [30:0]        grid_spacing;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic [6:0]         last_column;
  logic [6:0]         last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_spacing <= 31'h0001_0000;
      origin_x     <= '0;
      origin_y     <= '0;
      origin_z     <= '0;
      last_column  <= 7'd127;
      last_row     <= 7'd127;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_SPACING: grid_spacing <= cfg_data[30:0];
        REG_ORIGIN_X:     origin_x     <= signed'(cfg_data);
        REG_ORIGIN_Y:     origin_y     <= signed'(cfg_data);
        REG_ORIGIN_Z:     origin_z     <= signed'(cfg_data);
        REG_LAST_COLUMN:  last_column  <= cfg_data[6:0];
        REG_LAST_ROW:     last_row     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  req_item_t          item;
  logic signed [31:0] low_s;
  logic signed [31:0] high_s;
  logic [37:0]        wx;
  logic [37:0]        wz;
  logic               res_collides;
  logic               res_on_grid;
  logic signed [31:0] res_surface;

  logic [IDX_W-1:0]   col0, col1, row0, row1;
  logic [FRAC_W-1:0]  fx, fz;
  logic [2:0]         rd_cnt;
  logic [2:0]         step;
  logic signed [31:0] samp [4];
  logic signed [32:0] diff;
  logic signed [31:0] base;
  logic [FRAC_W-1:0]  frac;
  logic signed [49:0] prod;
  logic signed [31:0] h0;

  // Spacing of zero acts as one LSB
  logic [30:0] spacing_eff;
  assign spacing_eff = (grid_spacing == '0) ? 31'd1 : grid_spacing;

  // Clamp a cell index to the store
  function automatic logic [IDX_W-1:0] clamp_idx(input logic [7:0] v);
    logic [IDX_W-1:0] r;
    if ({3'b000, v} > 11'(MAP_SIDE - 1)) begin
      r = IDX_W'(MAP_SIDE - 1);
    end else begin
      r = IDX_W'(v);
    end
    return r;
  endfunction

  // Extent, center and overlap checks
  logic signed [GEO_W-1:0] mnx, mxx, mnz, mxz, ox2, oz2, wxs, wzs, gx2, gz2;
  logic signed [33:0]      mny34, top34;
  logic                    overlap, below_top, on_grid_c, go;

  always_comb begin
    mnx   = GEO_W'(item.box_min_x);
    mxx   = GEO_W'(item.box_max_x);
    mnz   = GEO_W'(item.box_min_z);
    mxz   = GEO_W'(item.box_max_z);
    ox2   = GEO_W'(origin_x) <<< 1;
    oz2   = GEO_W'(origin_z) <<< 1;
    wxs   = signed'(GEO_W'(wx));
    wzs   = signed'(GEO_W'(wz));
    gx2   = mnx + mxx - ox2 + wxs;
    gz2   = mnz + mxz - oz2 + wzs;
    overlap = !(((mxx <<< 1) < ox2 - wxs) || ((mnx <<< 1) > ox2 + wxs) ||
                ((mxz <<< 1) < oz2 - wzs) || ((mnz <<< 1) > oz2 + wzs));
    mny34 = 34'(item.box_min_y);
    top34 = 34'(origin_y) + 34'(high_s);
    below_top = mny34 <= top34;
    on_grid_c = (gx2 >= 0) && (gx2 <= (wxs <<< 1)) &&
                (gz2 >= 0) && (gz2 <= (wzs <<< 1));
    go = overlap && below_top && on_grid_c;
  end

  // Dividers for the two grid axes
  logic              div_start;
  logic [DEN_W-1:0]  den2;
  logic              done_x, done_z;
  logic [QUOT_W-1:0] qx, qz;

  assign div_start = (state == ST_CHECK) && go;
  assign den2      = {spacing_eff, 1'b0};

  hmtc_div u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (gx2[NUM_W-1:0]),
    .den   (den2),
    .done  (done_x),
    .quot  (qx)
  );

  hmtc_div u_div_z (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (gz2[NUM_W-1:0]),
    .den   (den2),
    .done  (done_z),
    .quot  (qz)
  );

  // Neighbor cell indexes from the quotients
  logic [7:0] x0c, z0c, x1c, z1c;
  always_comb begin
    x0c = qx[QUOT_W-1:FRAC_W];
    z0c = qz[QUOT_W-1:FRAC_W];
    x1c = (x0c + 8'd1 > {1'b0, last_column}) ? {1'b0, last_column} : x0c + 8'd1;
    z1c = (z0c + 8'd1 > {1'b0, last_row}) ? {1'b0, last_row} : z0c + 8'd1;
  end

  // Height memory: one write port, one registered read port
  logic [SW-1:0]     mem [DEPTH];
  logic [SW-1:0]     rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic              wr_en;
  logic              load_in_range;

  assign load_in_range = ({4'b0000, item.sample_row} < 11'(MAP_SIDE)) &&
                         ({4'b0000, item.sample_column} < 11'(MAP_SIDE));
  assign wr_en   = (state == ST_LOAD) && load_in_range;
  assign wr_addr = ADDR_W'(item.sample_row) * ADDR_W'(MAP_SIDE) +
                   ADDR_W'(item.sample_column);
  assign rd_en   = (state == ST_READ) && (rd_cnt < 3'd4);

  always_comb begin
    case (rd_cnt[1:0])
      2'd0:    rd_addr = ADDR_W'(row0) * ADDR_W'(MAP_SIDE) + ADDR_W'(col0);
      2'd1:    rd_addr = ADDR_W'(row0) * ADDR_W'(MAP_SIDE) + ADDR_W'(col1);
      2'd2:    rd_addr = ADDR_W'(row1) * ADDR_W'(MAP_SIDE) + ADDR_W'(col0);
      default: rd_addr = ADDR_W'(row1) * ADDR_W'(MAP_SIDE) + ADDR_W'(col1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= item.sample_height[SW-1:0];
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Loaded height at store width
  logic signed [31:0] load_h;
  logic signed [SW-1:0] load_trunc;
  assign load_trunc = signed'(item.sample_height[SW-1:0]);
  assign load_h     = 32'(load_trunc);

  logic signed [SW-1:0] rd_trunc;
  assign rd_trunc = signed'(rd_data);

  // Shared blend: base + floor(diff * frac / 2^16)
  logic signed [33:0] ip_sum;
  logic signed [33:0] world;
  assign ip_sum = 34'(base) + prod[49:16];
  assign world  = 34'(origin_y) + ip_sum;

  kind_t item_kind_in;
  assign item_kind_in = kind_t'(req.item.kind);

  // Controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = (item_kind_in == KIND_LOAD) ? ST_LOAD : ST_EXTENT;
        end
      end
      ST_LOAD:   state_next = ST_FINISH;
      ST_EXTENT: state_next = ST_CHECK;
      ST_CHECK:  state_next = go ? ST_DIVIDE : ST_FINISH;
      ST_DIVIDE: if (done_x && done_z) state_next = ST_READ;
      ST_READ:   if (rd_cnt == 3'd4) state_next = ST_INTERP;
      ST_INTERP: if (step == 3'd6) state_next = ST_FINISH;
      ST_FINISH: if (!rsp.valid || rsp.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Running bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      low_s  <= '0;
      high_s <= '0;
    end else if (wr_en) begin
      if (load_h < low_s)  low_s  <= load_h;
      if (load_h > high_s) high_s <= load_h;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          item         <= req.item;
          res_collides <= 1'b0;
          res_on_grid  <= 1'b0;
          res_surface  <= '0;
        end
      end
      ST_EXTENT: begin
        wx <= 38'(last_column) * 38'(spacing_eff);
        wz <= 38'(last_row) * 38'(spacing_eff);
      end
      ST_CHECK: begin
        res_on_grid <= on_grid_c;
      end
      ST_DIVIDE: begin
        col0   <= clamp_idx(x0c);
        col1   <= clamp_idx(x1c);
        row0   <= clamp_idx(z0c);
        row1   <= clamp_idx(z1c);
        fx     <= qx[FRAC_W-1:0];
        fz     <= qz[FRAC_W-1:0];
        rd_cnt <= '0;
      end
      ST_READ: begin
        if (rd_cnt != 3'd0) begin
          samp[rd_cnt[1:0] - 2'd1] <= 32'(rd_trunc);
        end
        rd_cnt <= rd_cnt + 3'd1;
        step   <= '0;
      end
      ST_INTERP: begin
        step <= step + 3'd1;
        case (step)
          3'd0: begin
            diff <= 33'(samp[1]) - 33'(samp[0]);
            base <= samp[0];
            frac <= fx;
          end
          3'd2: begin
            h0   <= ip_sum[31:0];
            diff <= 33'(samp[3]) - 33'(samp[2]);
            base <= samp[2];
          end
          3'd4: begin
            diff <= 33'(ip_sum) - 33'(h0);
            base <= h0;
            frac <= fz;
          end
          3'd6: begin
            res_surface  <= sat32(world);
            res_collides <= 34'(item.box_min_y) <= world;
          end
          default: begin
            prod <= diff * signed'({1'b0, frac});
          end
        endcase
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == ST_FINISH && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!rsp.valid || rsp.ready)) begin
      rsp.item.collides       <= res_collides;
      rsp.item.on_grid        <= res_on_grid;
      rsp.item.surface_height <= res_surface;
      rsp.item.terrain_low    <= sat32(34'(origin_y) + 34'(low_s));
      rsp.item.terrain_high   <= sat32(34'(origin_y) + 34'(high_s));
    end
  end

endmodule
`default_nettype wire

// ----- src/hmtc_check.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// hmtc_check: port-level checks for the terrain collision core
// Watches the request and response channels over time.
// ---------------------------------------------------------------------------
module hmtc_check
  import hmtc_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  hmtc_req_if.sink   req,
  hmtc_rsp_if.source rsp
);

  // Stalled response holds its valid
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid)
    else $error("response valid dropped while stalled");

  // One item at a time: no request taken right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while busy");

  // Terrain bounds are ordered
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.item.terrain_low <= rsp.item.terrain_high)
    else $error("terrain low above terrain high");

  // A collision is only reported over the grid
  a_hit_on_grid: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.item.collides |-> rsp.item.on_grid)
    else $error("collision reported off grid");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("response valid after reset");

endmodule

bind heightmap_terrain_collision_core hmtc_check u_hmtc_check (
  .clk (clk),
  .rst (rst),
  .req (req),
  .rsp (rsp)
);
`default_nettype wire
